// File: rtl/sfd_pkg.sv
package sfd_pkg;

  // sync pair that opens every frame
  localparam logic [7:0] SYNC_A = 8'hEF;
  localparam logic [7:0] SYNC_B = 8'hDD;

  // frame types below this have a fixed length
  localparam logic [7:0] NUM_TYPES = 8'd9;

  // frame type codes
  localparam logic [7:0] TYPE_POWER     = 8'd0;
  localparam logic [7:0] TYPE_HOLD      = 8'd1;
  localparam logic [7:0] TYPE_TARGET    = 8'd2;
  localparam logic [7:0] TYPE_CURRENT   = 8'd3;
  localparam logic [7:0] TYPE_COUNTDOWN = 8'd4;
  localparam logic [7:0] TYPE_LIFT      = 8'd8;

  // result beat packing
  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned OUT_USER_W = 11;

  typedef enum logic [1:0] {
    PH_HUNT_A  = 2'd0,
    PH_HUNT_B  = 2'd1,
    PH_IN_FRAME = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_VALUE = 3'd1,
    ST_BAD_TYPE  = 3'd2,
    ST_OVERLONG  = 3'd3,
    ST_TRUNCATED = 3'd4
  } frame_status_t;

  // whole frame length, type byte included, for the known types
  function automatic logic [2:0] type_len(input logic [7:0] t);
    logic [2:0] len;
    len = 3'd3;
    case (t) inside
      TYPE_TARGET, TYPE_CURRENT, TYPE_COUNTDOWN, 8'd5: len = 3'd4;
      default: len = 3'd3;
    endcase
    return len;
  endfunction

endpackage

// File: rtl/status_frame_deframer.sv
// Status frame deframer. Received bytes arrive one per beat on in_tdata, with
// in_tlast marking the last byte of a notification. The block hunts for the
// sync pair EF DD, takes the next byte as the frame type and, for types 0 to 8,
// completes the frame after 3 or 4 bytes (type byte included). A completed
// frame updates the appliance status (power, hold, target and current
// temperature, units, countdown, lifted) and produces one result beat carrying
// the frame type, a status code and the full status after the frame. An EF DD
// pair inside a frame cuts it short: a frame of at least one byte is reported
// as truncated (status 4; status 2 if its type is unknown) with no status
// update. A frame of unknown type reaching MAX_FRAME bytes is dropped with
// status 3. Bytes are ignored entirely while cfg link_up is 0; write it only
// while the block is idle. Throughput is one byte per clock while no result
// beat is held by out_tready; a byte goes through an input register and then
// the result register, and a result beat held by out_tready still lets one
// more byte be taken into the input register.
module status_frame_deframer #(
  parameter int unsigned MAX_FRAME = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration: bit 0 link_up
  input  logic                              cfg_we,
  input  logic                              cfg_wdata,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,  // [7:0] data_byte
  input  logic                              in_tlast,  // last_in_packet
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [0] power_on, [1] hold_on, [9:2] target_temp, [17:10] current_temp,
  // [18] fahrenheit, [26:19] countdown_value, [27] lifted_off, [31:28] zero
  output logic [sfd_pkg::OUT_DATA_W-1:0]    out_tdata,
  // [7:0] frame_type, [10:8] frame_status
  output logic [sfd_pkg::OUT_USER_W-1:0]    out_tuser
);
  import sfd_pkg::*;

  localparam int unsigned PW = $clog2(MAX_FRAME);
  localparam logic [PW-1:0] POS_LAST = PW'(MAX_FRAME - 1);

  // input register
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;

  // link enable
  logic link_up_r;

  // deframer control
  phase_t        phase_r, phase_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic          pending_r, pending_nxt;
  logic [7:0]    head0_r, head1_r, head2_r;

  // appliance status
  logic       power_r, power_nxt;
  logic       hold_r, hold_nxt;
  logic [7:0] target_r, target_nxt;
  logic [7:0] current_r, current_nxt;
  logic       fahr_r, fahr_nxt;
  logic [7:0] countdown_r, countdown_nxt;
  logic       lifted_r, lifted_nxt;

  // result register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_USER_W-1:0] out_user_r;

  logic          advance;
  logic          work;
  logic          pend_hit;
  logic          in_frame;
  logic [7:0]    frame_typ;
  logic          known_typ;
  logic          complete;
  logic          overlong;
  logic          emit;
  frame_status_t status;
  frame_status_t apply_st;

  // the byte in the input register moves on once the result slot is free
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign work      = advance && link_up_r;

  // ef followed by dd inside a frame closes the frame before the ef
  assign pend_hit  = pending_r && (phase_r == PH_IN_FRAME) && (in_byte_r == SYNC_B);
  assign in_frame  = (phase_r == PH_IN_FRAME) && !pend_hit;

  // type byte as it stands after this byte is stored
  assign frame_typ = (pos_r == '0) ? in_byte_r : head0_r;
  assign known_typ = frame_typ < NUM_TYPES;
  assign complete  = in_frame && (pos_r != '0) && known_typ &&
                     (pos_r >= PW'(type_len(frame_typ) - 3'd1));
  assign overlong  = in_frame && !complete && (pos_r >= POS_LAST);

  // truncated frames need at least the type and one more byte
  assign emit = work && ((pend_hit && (pos_r >= PW'(2))) || complete || overlong);

  // control next state
  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    pending_nxt = pending_r;
    if (work) begin
      pending_nxt = 1'b0;
      if (pend_hit) begin
        phase_nxt = PH_IN_FRAME;
        pos_nxt   = '0;
      end else begin
        case (phase_r)
          PH_HUNT_B: begin
            if (in_byte_r == SYNC_B) begin
              phase_nxt = PH_IN_FRAME;
              pos_nxt   = '0;
            end
          end
          PH_IN_FRAME: begin
            if (complete) begin
              phase_nxt = PH_HUNT_B;
              pos_nxt   = '0;
            end else if (overlong) begin
              phase_nxt = PH_HUNT_A;
              pos_nxt   = '0;
            end else begin
              pending_nxt = (in_byte_r == SYNC_A) && !in_last_r;
              pos_nxt     = pos_r + PW'(1);
            end
          end
          default: begin
            // unused phase code behaves as hunting the first sync byte
            if (in_byte_r == SYNC_A) begin
              phase_nxt = PH_HUNT_B;
              pos_nxt   = '0;
            end
          end
        endcase
      end
    end
  end

  // status update for a completed frame
  always_comb begin
    power_nxt     = power_r;
    hold_nxt      = hold_r;
    target_nxt    = target_r;
    current_nxt   = current_r;
    fahr_nxt      = fahr_r;
    countdown_nxt = countdown_r;
    lifted_nxt    = lifted_r;
    apply_st      = ST_OK;
    case (frame_typ)
      TYPE_POWER: begin
        if (head1_r == 8'd1)      power_nxt = 1'b1;
        else if (head1_r == 8'd0) power_nxt = 1'b0;
        else                      apply_st  = ST_BAD_VALUE;
      end
      TYPE_HOLD: begin
        if (head1_r == 8'd1)      hold_nxt = 1'b1;
        else if (head1_r == 8'd0) hold_nxt = 1'b0;
        else                      apply_st = ST_BAD_VALUE;
      end
      TYPE_TARGET: begin
        target_nxt = head1_r;
        fahr_nxt   = (head2_r == 8'd1);
      end
      TYPE_CURRENT: begin
        current_nxt = head1_r;
        fahr_nxt    = (head2_r == 8'd1);
      end
      TYPE_COUNTDOWN: countdown_nxt = head1_r;
      TYPE_LIFT: begin
        if (head1_r == 8'd0)      lifted_nxt = 1'b1;
        else if (head1_r == 8'd1) lifted_nxt = 1'b0;
        else                      apply_st   = ST_BAD_VALUE;
      end
      default: apply_st = ST_BAD_TYPE;
    endcase
  end

  // result status code
  always_comb begin
    if (pend_hit)      status = known_typ ? ST_TRUNCATED : ST_BAD_TYPE;
    else if (complete) status = apply_st;
    else               status = ST_OVERLONG;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      link_up_r   <= 1'b0;
      phase_r     <= PH_HUNT_A;
      pos_r       <= '0;
      pending_r   <= 1'b0;
      power_r     <= 1'b0;
      hold_r      <= 1'b0;
      target_r    <= '0;
      current_r   <= '0;
      fahr_r      <= 1'b0;
      countdown_r <= '0;
      lifted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) link_up_r <= cfg_wdata;
      if (in_tready) in_valid_r <= in_tvalid;
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      pending_r <= pending_nxt;
      if (work && complete) begin
        power_r     <= power_nxt;
        hold_r      <= hold_nxt;
        target_r    <= target_nxt;
        current_r   <= current_nxt;
        fahr_r      <= fahr_nxt;
        countdown_r <= countdown_nxt;
        lifted_r    <= lifted_nxt;
      end
      if (advance)         out_valid_r <= emit;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
    if (work && in_frame) begin
      if (pos_r == PW'(0)) head0_r <= in_byte_r;
      if (pos_r == PW'(1)) head1_r <= in_byte_r;
      if (pos_r == PW'(2)) head2_r <= in_byte_r;
    end
    if (emit) begin
      out_user_r <= {status, frame_typ};
      if (complete) begin
        out_data_r <= {4'b0000, lifted_nxt, countdown_nxt, fahr_nxt, current_nxt,
                       target_nxt, hold_nxt, power_nxt};
      end else begin
        out_data_r <= {4'b0000, lifted_r, countdown_r, fahr_r, current_r,
                       target_r, hold_r, power_r};
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// File: rtl/sfd_checker.sv
module sfd_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [sfd_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [sfd_pkg::OUT_USER_W-1:0] out_tuser
);
  import sfd_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // ok status only for types that update the status
  a_ok_type: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[10:8] == ST_OK) |->
      (out_tuser[7:0] == TYPE_POWER) || (out_tuser[7:0] == TYPE_HOLD) ||
      (out_tuser[7:0] == TYPE_TARGET) || (out_tuser[7:0] == TYPE_CURRENT) ||
      (out_tuser[7:0] == TYPE_COUNTDOWN) || (out_tuser[7:0] == TYPE_LIFT))
    else $error("ok status on a type without status update");

  // known types always finish before the length limit
  a_overlong_type: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[10:8] == ST_OVERLONG) |-> out_tuser[7:0] >= NUM_TYPES)
    else $error("overlong drop of a known type");

  // only defined status codes, padding stays zero
  a_code_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[10:8] <= ST_TRUNCATED) && (out_tdata[31:28] == 4'b0000))
    else $error("undefined status code or padding set");

endmodule

bind status_frame_deframer sfd_checker u_sfd_checker (.*);

// File: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import sfd_pkg::*;

  localparam int FRAME_LIMIT = 64;
  localparam int LONG_HOLD = 300;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;
  logic in_tvalid;
  logic in_tready;
  logic [7:0] in_tdata;  // [7:0] data_byte
  logic in_tlast;        // last_in_packet
  logic out_tvalid;
  logic out_tready;
  // [0] power_on, [1] hold_on, [9:2] target_temp, [17:10] current_temp,
  // [18] fahrenheit, [26:19] countdown_value, [27] lifted_off
  logic [OUT_DATA_W-1:0] out_tdata;
  // [7:0] frame_type, [10:8] frame_status
  logic [OUT_USER_W-1:0] out_tuser;

  // one status report as the result beat carries it
  typedef struct {
    logic [7:0] ftype;
    frame_status_t fstat;
    logic power;
    logic hold;
    logic [7:0] target;
    logic [7:0] current;
    logic fahr;
    logic [7:0] countdown;
    logic lifted;
  } status_report_t;

  // mirror of the deframer: tracks sync hunting and the appliance status,
  // queues the report each finished frame should produce
  class deframer_scoreboard;
    bit link_up;
    phase_t hunt;
    logic [5:0] frame_pos;
    logic [7:0] frame_head [3];
    bit sync_deferred;
    logic power, hold, fahr, lifted;
    logic [7:0] target, current, countdown;
    byte unsigned frame_lengths [9];
    status_report_t expected_reports[$];
    int unsigned errors;

    function new();
      frame_lengths = '{3, 3, 4, 4, 4, 4, 3, 3, 3};
      link_up = 1'b0;
      hunt = PH_HUNT_A;
      frame_pos = '0;
      frame_head = '{8'd0, 8'd0, 8'd0};
      sync_deferred = 1'b0;
      power = 1'b0;
      hold = 1'b0;
      fahr = 1'b0;
      lifted = 1'b0;
      target = '0;
      current = '0;
      countdown = '0;
      errors = 0;
    endfunction

    function void queue_report(logic [7:0] t, frame_status_t st);
      status_report_t r;
      r.ftype = t;
      r.fstat = st;
      r.power = power;
      r.hold = hold;
      r.target = target;
      r.current = current;
      r.fahr = fahr;
      r.countdown = countdown;
      r.lifted = lifted;
      expected_reports.push_back(r);
    endfunction

    // status update for a complete frame of known type
    function frame_status_t update_status(logic [7:0] t);
      logic [7:0] v;
      v = frame_head[1];
      case (t)
        TYPE_POWER: begin
          if (v > 8'd1) return ST_BAD_VALUE;
          power = v[0];
        end
        TYPE_HOLD: begin
          if (v > 8'd1) return ST_BAD_VALUE;
          hold = v[0];
        end
        TYPE_TARGET: begin
          target = v;
          fahr = (frame_head[2] == 8'd1);
        end
        TYPE_CURRENT: begin
          current = v;
          fahr = (frame_head[2] == 8'd1);
        end
        TYPE_COUNTDOWN: countdown = v;
        TYPE_LIFT: begin
          // 0 means off the base
          if (v > 8'd1) return ST_BAD_VALUE;
          lifted = ~v[0];
        end
        default: return ST_BAD_TYPE;
      endcase
      return ST_OK;
    endfunction

    function void note_byte(logic [7:0] rx, logic ends_packet);
      logic [7:0] t;
      frame_status_t st;
      if (!link_up) return;
      // deferred sync: EF seen last beat, DD now cuts the frame short
      if (sync_deferred) begin
        sync_deferred = 1'b0;
        if (hunt == PH_IN_FRAME && rx == SYNC_B) begin
          if (frame_pos >= 2)
            queue_report(frame_head[0],
                         frame_head[0] < NUM_TYPES ? ST_TRUNCATED : ST_BAD_TYPE);
          frame_pos = '0;
          return;
        end
      end
      if (hunt == PH_HUNT_B) begin
        if (rx == SYNC_B) begin
          hunt = PH_IN_FRAME;
          frame_pos = '0;
        end
        return;
      end
      if (hunt != PH_IN_FRAME) begin
        if (rx == SYNC_A) begin
          hunt = PH_HUNT_B;
          frame_pos = '0;
        end
        return;
      end
      if (frame_pos < 3) frame_head[frame_pos] = rx;
      t = frame_head[0];
      if (frame_pos > 0 && t < NUM_TYPES && frame_pos + 1 >= frame_lengths[t]) begin
        st = update_status(t);
        frame_pos = '0;
        hunt = PH_HUNT_B;
        queue_report(t, st);
        return;
      end
      if (frame_pos >= FRAME_LIMIT - 1) begin
        hunt = PH_HUNT_A;
        frame_pos = '0;
        queue_report(t, ST_OVERLONG);
        return;
      end
      if (rx == SYNC_A && !ends_packet) sync_deferred = 1'b1;
      frame_pos++;
    endfunction

    function void compare_field(string what, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= 10)
          $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, what, want, got);
      end
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data, logic [OUT_USER_W-1:0] user);
      status_report_t e;
      if (expected_reports.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected result beat, type %0h status %0d",
                   $realtime, user[7:0], user[10:8]);
        return;
      end
      e = expected_reports.pop_front();
      compare_field("frame_type", e.ftype, user[7:0]);
      compare_field("frame_status", 8'(e.fstat), 8'(user[10:8]));
      compare_field("power_on", 8'(e.power), 8'(data[0]));
      compare_field("hold_on", 8'(e.hold), 8'(data[1]));
      compare_field("target_temp", e.target, data[9:2]);
      compare_field("current_temp", e.current, data[17:10]);
      compare_field("fahrenheit", 8'(e.fahr), 8'(data[18]));
      compare_field("countdown_value", e.countdown, data[26:19]);
      compare_field("lifted_off", 8'(e.lifted), 8'(data[27]));
    endfunction
  endclass

  deframer_scoreboard sb = new();

  int send_idle;
  int recv_idle;
  bit stall_req;
  int live_bytes;

  // directed beats: bit 8 is tlast
  logic [8:0] directed_beats [30] = '{
    // power on
    9'h0EF, 9'h0DD, 9'h000, 9'h001, 9'h000,
    // target 255, fahrenheit, extreme data bytes
    9'h0EF, 9'h0DD, 9'h002, 9'h0FF, 9'h001, 9'h000,
    // lifted off its base
    9'h0EF, 9'h0DD, 9'h008, 9'h000, 9'h0FF,
    // current frame cut short by a sync pair, then a type that is not handled
    9'h0EF, 9'h0DD, 9'h003, 9'h0EF, 9'h0DD, 9'h005, 9'h000, 9'h000, 9'h000,
    // EF ending its packet is plain data: hold with a bad value
    9'h0EF, 9'h0DD, 9'h001, 9'h1EF, 9'h0DD
  };

  always #2 clk = ~clk;

  status_frame_deframer #(.MAX_FRAME(FRAME_LIMIT)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // offer one byte, idling at random first, and wait for the beat
  task automatic send_byte(input logic [7:0] b, input logic l);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= l;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (sb.link_up) live_bytes++;
    sb.note_byte(b, l);
  endtask

  function automatic logic rand_last();
    return ($urandom_range(7) == 0);
  endfunction

  // payload byte leaning towards the sync values
  function automatic logic [7:0] frame_byte();
    int r;
    r = $urandom_range(15);
    if (r == 0) return SYNC_A;
    if (r == 1) return SYNC_B;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (b == SYNC_A) b = 8'h00;
    return b;
  endfunction

  // sync pair and a frame of known type with random content
  task automatic good_frame();
    logic [7:0] ftype;
    logic [7:0] val;
    ftype = 8'($urandom_range(8));
    case (ftype)
      TYPE_POWER, TYPE_HOLD, TYPE_LIFT:
        val = ($urandom_range(3) == 0) ? frame_byte() : 8'($urandom_range(1));
      default: val = frame_byte();
    endcase
    send_byte(SYNC_A, rand_last());
    send_byte(SYNC_B, rand_last());
    send_byte(ftype, rand_last());
    send_byte(val, rand_last());
    if (sb.frame_lengths[ftype] == 4)
      send_byte(($urandom_range(1) == 0) ? 8'd1 : frame_byte(), rand_last());
    send_byte(frame_byte(), rand_last());
  endtask

  task automatic send_frame();
    int kind;
    int n;
    logic [7:0] ftype;
    kind = $urandom_range(99);
    if (kind < 62) begin
      good_frame();
    end else if (kind < 77) begin
      // partial frame cut short by the next sync pair
      send_byte(SYNC_A, 1'b0);
      send_byte(SYNC_B, 1'b0);
      if ($urandom_range(7) != 0) begin
        ftype = ($urandom_range(2) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(8));
        send_byte(ftype, 1'b0);
        n = (ftype < NUM_TYPES) ? 0 : $urandom_range(4);
        repeat (n) send_byte(plain_byte(), rand_last());
      end
      good_frame();
    end else if (kind < 79) begin
      // unknown type that never meets a sync pair
      send_byte(SYNC_A, 1'b0);
      send_byte(SYNC_B, 1'b0);
      send_byte(8'($urandom_range(255, 9)), 1'b1);
      repeat ($urandom_range(67, 63)) send_byte(plain_byte(), rand_last());
    end else begin
      repeat ($urandom_range(6, 1)) send_byte(8'($urandom_range(255)), rand_last());
    end
  endtask

  task automatic random_bytes(input int n);
    int stop_at;
    stop_at = live_bytes + n;
    while (live_bytes < stop_at) send_frame();
  endtask

  // stop offering, let all reports out, then allow for the pipeline
  task automatic quiesce();
    in_tvalid <= 1'b0;
    while (sb.expected_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_link(input logic up);
    cfg_we <= 1'b1;
    cfg_wdata <= up;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.link_up = up;
  endtask

  // receiver: random stalls, one long hold on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready)
        sb.check_result(out_tdata, out_tuser);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (stall_req) begin
        stall_req = 1'b0;
        hold_left = LONG_HOLD;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tlast <= 1'b0;
    send_idle = 20;
    recv_idle = 46;
    stall_req = 1'b0;
    live_bytes = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // link is down out of reset, so these frames must be ignored
    repeat (3) good_frame();
    quiesce();
    write_link(1'b1);

    foreach (directed_beats[i]) send_byte(directed_beats[i][7:0], directed_beats[i][8]);
    random_bytes(460);
    quiesce();

    // link drop mid-stream: state is held, bytes ignored
    write_link(1'b0);
    repeat (8) send_frame();
    quiesce();
    write_link(1'b1);

    send_idle = 46;
    recv_idle = 20;
    random_bytes(480);
    quiesce();

    // full rate, with one long receiver hold so the block backs up
    send_idle = 0;
    recv_idle = 0;
    stall_req = 1'b1;
    random_bytes(490);
    quiesce();

    if (sb.errors == 0 && sb.expected_reports.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
